// File: src/ptc_pkg.sv
package ptc_pkg;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;
    localparam int REG_T1_T2 = 0;
    localparam int REG_T3_P1 = 1;
    localparam int REG_P2_P3 = 2;
    localparam int REG_P4_P5 = 3;
    localparam int REG_P6_P7 = 4;
    localparam int REG_P8_P9 = 5;

    // Field widths.
    localparam int RAW_W   = 20;
    localparam int CENTI_W = 24;
    localparam int PRES_W  = 32;

    // Divider shape: numerator is |m| * 6250, the dividend is that times 2^40,
    // and the quotient is kept to 48 bits (larger values clamp).
    localparam int NUM_W     = 76;
    localparam int DEN_W     = 79;
    localparam int Q_W       = 48;
    localparam int REM_W     = DEN_W + 1;
    localparam int NUM_SHIFT = 40;
    localparam int LOW_NUM   = Q_W - NUM_SHIFT;

    localparam logic [12:0]        P_SCALE       = 13'd6250;
    localparam logic signed [24:0] T_FINE_OFFSET = 25'sd128000;

    // Sideband carried through the divider with each item.
    typedef struct packed {
        logic signed [CENTI_W-1:0] centi;
        logic                      invalid;
        logic                      neg;
    } ptc_side_t;

endpackage

// File: src/ptc_div.sv
module ptc_div import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  ptc_side_t        side_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quo,
    output ptc_side_t        side_out
);

    // One quotient bit per stage, restoring division.
    logic [REM_W-1:0] rem_reg  [Q_W];
    logic [DEN_W-1:0] den_reg  [Q_W];
    logic [Q_W-1:0]   bits_reg [Q_W];
    logic [Q_W-1:0]   q_reg    [Q_W+1];
    logic             ovf_reg  [Q_W+1];
    ptc_side_t        side_reg [Q_W+1];
    logic [Q_W:0]     v_reg;

    // Valid bits advance together with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[Q_W-1:0], in_valid};
        end
    end

    // Entry stage: the top of the dividend becomes the first remainder. If it
    // already reaches the divisor, the quotient is 2^48 or more and clamps.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= REM_W'(num[NUM_W-1:LOW_NUM]);
            den_reg[0]  <= den;
            bits_reg[0] <= {num[LOW_NUM-1:0], {NUM_SHIFT{1'b0}}};
            q_reg[0]    <= '0;
            ovf_reg[0]  <= REM_W'(num[NUM_W-1:LOW_NUM]) >= REM_W'(den);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             ge;

        // Shift in the next dividend bit and try to subtract the divisor.
        assign trial = {rem_reg[k][REM_W-2:0], bits_reg[k][Q_W-1]};
        assign diff  = trial - REM_W'(den_reg[k]);
        assign ge    = trial >= REM_W'(den_reg[k]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[k+1]    <= {q_reg[k][Q_W-2:0], ge};
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < Q_W - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k+1]  <= ge ? diff : trial;
                    den_reg[k+1]  <= den_reg[k];
                    bits_reg[k+1] <= {bits_reg[k][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quo       = ovf_reg[Q_W] ? {Q_W{1'b1}} : q_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

// File: src/pressure_temperature_compensation.sv
// Channel   Signals                                          Direction
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data         in  (always ready)
// in        in_valid/in_ready, temp_sample, raw_pressure     in
// out       out_valid/out_ready, temperature_centi,          out
//           pressure_q24_8, pressure_invalid
//
// One beat is accepted per cycle while in_ready is high.
// Most of the depth is the bit-per-stage pressure divider: an entry stage and 48 quotient stages.
// Reset clears the calibration registers and all valid bits.
// A two-entry output buffer takes results; in_ready drops only when both are
// full, and the whole pipeline then holds until a result is taken.
module pressure_temperature_compensation import ptc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [RAW_W-1:0]          temp_sample,
    input  logic [RAW_W-1:0]          raw_pressure,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [CENTI_W-1:0] temperature_centi,
    output logic [PRES_W-1:0]         pressure_q24_8,
    output logic                      pressure_invalid
);

    logic [31:0] cal_reg [NUM_REGS];

    logic [15:0]        t1;
    logic [15:0]        p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [15:0]        p9_mag;
    logic               adv;
    logic               skid_full_reg;

    // Calibration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (int'(cfg_index) < NUM_REGS))
        begin
            cal_reg[cfg_index] <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    assign t1 = cal_reg[REG_T1_T2][15:0];
    assign t2 = cal_reg[REG_T1_T2][31:16];
    assign t3 = cal_reg[REG_T3_P1][15:0];
    assign p1 = cal_reg[REG_T3_P1][31:16];
    assign p2 = cal_reg[REG_P2_P3][15:0];
    assign p3 = cal_reg[REG_P2_P3][31:16];
    assign p4 = cal_reg[REG_P4_P5][15:0];
    assign p5 = cal_reg[REG_P4_P5][31:16];
    assign p6 = cal_reg[REG_P6_P7][15:0];
    assign p7 = cal_reg[REG_P6_P7][31:16];
    assign p8 = cal_reg[REG_P8_P9][15:0];
    assign p9 = cal_reg[REG_P8_P9][31:16];
    assign p9_mag = 16'(p9[15] ? -p9 : p9);

    // The pipeline moves whenever the output buffer has a free slot.
    assign adv      = !skid_full_reg;
    assign in_ready = adv;

    // Front section valid bits, stages one to ten.
    logic [9:0] vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= '0;
        end
        else if (adv)
        begin
            vf_reg <= {vf_reg[8:0], in_valid};
        end
    end

    logic signed [21:0]        d1_reg;
    logic [RAW_W-1:0]          b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg, b7_reg;
    logic signed [37:0]        dt2_2_reg;
    logic signed [41:0]        dsq2_reg;
    logic signed [57:0]        n3_reg;
    logic                      nneg4_reg;
    logic [56:0]               nmag4_reg;
    logic signed [CENTI_W-1:0] c5_reg, c6_reg, c7_reg, c8_reg, c9_reg, c10_reg;
    logic signed [24:0]        u5_reg;
    logic signed [47:0]        uu6_reg;
    logic signed [40:0]        p2u6_reg, p5u6_reg, p2u7_reg, p5u7_reg;
    logic signed [63:0]        p3uu7_reg, p6uu7_reg;
    logic signed [63:0]        dd8_reg, m8_reg;
    logic [62:0]               mm9_reg, ddm9_reg;
    logic                      inv9_reg, neg9_reg, inv10_reg, neg10_reg;
    logic [NUM_W-1:0]          num10_reg;
    logic [DEN_W-1:0]          den10_reg;

    logic [59:0]               rsum5;
    logic signed [CENTI_W-1:0] cpos5;
    logic signed [24:0]        tf5;
    logic [20:0]               bdiff8;

    assign rsum5  = 60'(nmag4_reg) * 60'd5 + (60'd1 << 41);
    assign cpos5  = signed'(CENTI_W'(rsum5[59:42]));
    assign tf5    = signed'(25'(nmag4_reg[56:34]));
    assign bdiff8 = 21'h100000 - {1'b0, b7_reg};

    // Front section: temperature, then the divisor and numerator terms.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Offset of the raw temperature.
            d1_reg    <= signed'({2'b0, temp_sample}) - signed'({2'b0, t1, 4'b0});
            b1_reg    <= raw_pressure;
            // Linear and square terms.
            dt2_2_reg <= 38'(d1_reg) * 38'(t2);
            dsq2_reg  <= 42'(d1_reg) * 42'(d1_reg);
            b2_reg    <= b1_reg;
            // Temperature sum N.
            n3_reg    <= (58'(dt2_2_reg) <<< 20) + 58'(dsq2_reg) * 58'(t3);
            b3_reg    <= b2_reg;
            // Sign and magnitude of N.
            nneg4_reg <= n3_reg[57];
            nmag4_reg <= 57'(n3_reg[57] ? -n3_reg : n3_reg);
            b4_reg    <= b3_reg;
            // Rounded hundredths and the fine term relative to its centre.
            c5_reg    <= nneg4_reg ? -cpos5 : cpos5;
            u5_reg    <= (nneg4_reg ? -tf5 : tf5) - T_FINE_OFFSET;
            b5_reg    <= b4_reg;
            // Products of u.
            uu6_reg   <= 48'(u5_reg) * 48'(u5_reg);
            p2u6_reg  <= 41'(u5_reg) * 41'(p2);
            p5u6_reg  <= 41'(u5_reg) * 41'(p5);
            c6_reg    <= c5_reg;
            b6_reg    <= b5_reg;
            // Square terms scaled by their coefficients.
            p3uu7_reg <= 64'(uu6_reg) * 64'(p3);
            p6uu7_reg <= 64'(uu6_reg) * 64'(p6);
            p2u7_reg  <= p2u6_reg;
            p5u7_reg  <= p5u6_reg;
            c7_reg    <= c6_reg;
            b7_reg    <= b6_reg;
            // Divisor D and numerator M.
            dd8_reg   <= (64'sd1 <<< 55) + p3uu7_reg + (64'(p2u7_reg) <<< 20);
            m8_reg    <= (signed'({43'b0, bdiff8}) <<< 31) - p6uu7_reg
                         - (64'(p5u7_reg) <<< 17) - (64'(p4) <<< 35);
            c8_reg    <= c7_reg;
            // Magnitudes, quotient sign and the zero-divisor check.
            mm9_reg   <= 63'(m8_reg[63] ? -m8_reg : m8_reg);
            ddm9_reg  <= 63'(dd8_reg[63] ? -dd8_reg : dd8_reg);
            neg9_reg  <= m8_reg[63] ^ dd8_reg[63];
            inv9_reg  <= (p1 == 16'd0) || (dd8_reg == 64'sd0);
            c9_reg    <= c8_reg;
            // Divider operands.
            num10_reg <= NUM_W'(mm9_reg) * NUM_W'(P_SCALE);
            den10_reg <= DEN_W'(p1) * DEN_W'(ddm9_reg);
            inv10_reg <= inv9_reg;
            neg10_reg <= neg9_reg;
            c10_reg   <= c9_reg;
        end
    end

    ptc_side_t        side_in, side_out;
    logic             div_valid;
    logic [Q_W-1:0]   quo;

    assign side_in = '{centi: c10_reg, invalid: inv10_reg, neg: neg10_reg};

    ptc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (vf_reg[9]),
        .num      (num10_reg),
        .den      (den10_reg),
        .side_in  (side_in),
        .out_valid(div_valid),
        .quo      (quo),
        .side_out (side_out)
    );

    // Back section valid bits.
    logic [3:0] vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= '0;
        end
        else if (adv)
        begin
            vb_reg <= {vb_reg[2:0], div_valid};
        end
    end

    logic signed [48:0]  pf_a_reg, pf_b_reg, pf_c_reg;
    logic [63:0]         sm_a_reg;
    logic [Q_W-1:0]      q_a_reg;
    logic [55:0]         pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic signed [64:0]  t8_b_reg, t8_c_reg;
    logic [111:0]        prod_c_reg;
    logic signed [113:0] x_d_reg;
    logic signed [113:0] prod_s;
    logic                inv_a_reg, inv_b_reg, inv_c_reg, inv_d_reg;
    logic signed [CENTI_W-1:0] c_a_reg, c_b_reg, c_c_reg, c_d_reg;

    assign prod_s = signed'(114'(prod_c_reg));

    // Back section: p + P9*p*p/2^51 + P8*p/2^19 + P7*2^12, all scaled by 2^51.
    // The square term carries the sign of P9 alone.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pf_a_reg   <= side_out.neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
            sm_a_reg   <= 64'(quo) * 64'(p9_mag);
            q_a_reg    <= quo;
            inv_a_reg  <= side_out.invalid;
            c_a_reg    <= side_out.centi;
            // Partial products of |P9*p| by |p|.
            pp_ll_reg  <= 56'(sm_a_reg[31:0]) * 56'(q_a_reg[23:0]);
            pp_lh_reg  <= 56'(sm_a_reg[31:0]) * 56'(q_a_reg[47:24]);
            pp_hl_reg  <= 56'(sm_a_reg[63:32]) * 56'(q_a_reg[23:0]);
            pp_hh_reg  <= 56'(sm_a_reg[63:32]) * 56'(q_a_reg[47:24]);
            t8_b_reg   <= 65'(pf_a_reg) * 65'(p8);
            pf_b_reg   <= pf_a_reg;
            inv_b_reg  <= inv_a_reg;
            c_b_reg    <= c_a_reg;
            // Sum of the partial products.
            prod_c_reg <= 112'(pp_ll_reg) + (112'(pp_lh_reg) << 24)
                          + (112'(pp_hl_reg) << 32) + (112'(pp_hh_reg) << 56);
            t8_c_reg   <= t8_b_reg;
            pf_c_reg   <= pf_b_reg;
            inv_c_reg  <= inv_b_reg;
            c_c_reg    <= c_b_reg;
            // Full sum with the rounding half step for 1/256 Pa.
            x_d_reg    <= (p9[15] ? -prod_s : prod_s) + (114'(pf_c_reg) <<< 51)
                          + (114'(t8_c_reg) <<< 32) + (114'(p7) <<< 63)
                          + (114'sd1 <<< 58);
            inv_d_reg  <= inv_c_reg;
            c_d_reg    <= c_c_reg;
        end
    end

    // Final pressure: zero when negative or invalid, saturated above.
    logic [PRES_W-1:0] pres_d;

    always_comb
    begin
        priority if (inv_d_reg || x_d_reg[113])
        begin
            pres_d = '0;
        end
        else if (|x_d_reg[112:91])
        begin
            pres_d = '1;
        end
        else
        begin
            pres_d = x_d_reg[90:59];
        end
    end

    // Output register and skid slot.
    logic                      out_valid_reg;
    logic signed [CENTI_W-1:0] out_centi_reg, skid_centi_reg;
    logic [PRES_W-1:0]         out_pres_reg, skid_pres_reg;
    logic                      out_inv_reg, skid_inv_reg;
    logic                      out_take;

    assign out_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_full_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= vb_reg[3];
            end
        end
        else if (vb_reg[3] && !skid_full_reg)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_full_reg)
            begin
                out_centi_reg <= skid_centi_reg;
                out_pres_reg  <= skid_pres_reg;
                out_inv_reg   <= skid_inv_reg;
            end
            else
            begin
                out_centi_reg <= c_d_reg;
                out_pres_reg  <= pres_d;
                out_inv_reg   <= inv_d_reg;
            end
        end
        else if (!skid_full_reg)
        begin
            skid_centi_reg <= c_d_reg;
            skid_pres_reg  <= pres_d;
            skid_inv_reg   <= inv_d_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = out_centi_reg;
    assign pressure_q24_8    = out_pres_reg;
    assign pressure_invalid  = out_inv_reg;

endmodule
